/* rtl/cubic_bspline_curve_eval_unit_assert.svh */
// Assertion macros shared by the curve evaluator RTL.
`ifndef CUBIC_BSPLINE_CURVE_EVAL_UNIT_ASSERT_SVH
`define CUBIC_BSPLINE_CURVE_EVAL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define CBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbs assertion failed");
// Checked on every edge, reset included.
`define CBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("cbs assertion failed");
`else
`define CBS_ASSERT(lbl, clk, rst_n, prop)
`define CBS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/cbs_pkg.sv */
`timescale 1ns / 1ps

package cbs_pkg;

    localparam int NUM_CTRL   = 9;
    localparam int NUM_INNER  = 7;
    localparam int NUM_KNOTS  = 13;
    localparam int KNOT_W     = 3;
    localparam int DEN_W      = 2;
    localparam int SPAN_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int GUARD_BITS = 2;

    typedef logic [KNOT_W-1:0] t_knot;

    // Integer knots of the clamped uniform vector, in sixths of u.
    localparam t_knot KNOT_UNITS [NUM_KNOTS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6
    };

    // Control x positions, in sixths.
    localparam t_knot X_SIXTHS [NUM_CTRL] = '{
        3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd6
    };

    // Stage load enables of one de Boor level.
    typedef struct packed {
        logic s_a;
        logic s_b;
        logic s_c;
    } t_lvl_ld;

    function automatic t_knot knot_at(input logic [3:0] idx);
        t_knot res;
        res = '0;
        if (idx < 4'(NUM_KNOTS)) begin
            res = KNOT_UNITS[idx];
        end
        return res;
    endfunction

    // Knot span width (in sixths) that divides update j of level r in segment k.
    function automatic logic [DEN_W-1:0] den_units(input logic [SPAN_W-1:0] k,
                                                   input int j, input int r);
        logic [3:0] lo;
        logic [3:0] hi;
        t_knot      d;
        lo = 4'(k) + 4'(j);
        hi = lo + 4'(4 - r);
        d  = knot_at(hi) - knot_at(lo);
        return DEN_W'(d);
    endfunction

endpackage

/* rtl/cbs_if.sv */
`timescale 1ns / 1ps

interface cbs_req_if #(parameter int U_FRAC_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [U_FRAC_BITS:0] param_u;

    modport source (output valid, output param_u, input ready);
    modport sink (input valid, input param_u, output ready);
endinterface

interface cbs_rsp_if #(parameter int U_FRAC_BITS = 16, parameter int Y_BITS = 16);
    logic                     valid;
    logic                     ready;
    logic [U_FRAC_BITS:0]     point_x;
    logic signed [Y_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

/* rtl/cbs_deboor_lvl.sv */
`timescale 1ns / 1ps

// One level of the de Boor triangle for both lanes (x and y).
// Stage A: difference times (v - knot). Stage B: round-shift, then
// reciprocal multiply for a span of three. Stage C: pick quotient, add.
module cbs_deboor_lvl import cbs_pkg::*; #(
    parameter int R = 1,
    parameter int F = 16,
    parameter int W = 22
) (
    input  logic                i_clk,
    input  t_lvl_ld             i_ld,
    input  logic [F+2:0]        i_v,
    input  logic [SPAN_W-1:0]   i_k_a,
    input  logic [SPAN_W-1:0]   i_k_b,
    input  logic signed [W-1:0] i_w [2][4],
    output logic signed [W-1:0] o_w [2][4]
);

    localparam int TW = F + 4;
    localparam int DW = W + 1;
    localparam int PW = DW + TW;
    localparam int QW = W + 4;
    localparam int NB = QW + 1;
    localparam int SH = NB + 1;
    localparam logic [NB-1:0] RECIP = NB'(((65'd1 << SH) + 65'd2) / 65'd3);
    localparam logic [NB-1:0] QBIAS = NB'(3) << (QW - 1);
    localparam logic [NB-1:0] QHALF = NB'(1) << (QW - 1);

    logic signed [TW-1:0]   w_t    [R:3];
    logic [DEN_W-1:0]       n_m    [R:3];
    logic [DEN_W-1:0]       r_m    [R:3];
    logic signed [PW-1:0]   r_prod [2][R:3];
    logic signed [QW-1:0]   n_q    [2][R:3];
    logic signed [QW-1:0]   r_q    [2][R:3];
    logic [NB-1:0]          n_qb   [2][R:3];
    logic [2*NB-1:0]        r_rq   [2][R:3];
    logic signed [W-1:0]    r_wa   [2][4];
    logic signed [W-1:0]    r_wb   [2][4];
    logic signed [W-1:0]    r_wc   [2][4];

    always_ff @(posedge i_clk) begin
        if (i_ld.s_a) begin
            r_wa <= i_w;
        end
        if (i_ld.s_b) begin
            r_wb <= r_wa;
        end
    end

    for (genvar j = R; j <= 3; j++) begin : g_upd
        assign w_t[j] = $signed(TW'(i_v))
                      - $signed(TW'({knot_at(4'(i_k_a) + 4'(j)), {F{1'b0}}}));
        assign n_m[j] = den_units(i_k_b, j, R);

        always_ff @(posedge i_clk) begin
            if (i_ld.s_b) begin
                r_m[j] <= n_m[j];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [QW-1:0] n_quo;
            logic signed [W-1:0]  n_wnew;

            // floor((2a + m*ONE) / (2*ONE)), exact in QW bits
            assign n_q[l][j]  = QW'((r_prod[l][j]
                              + $signed(PW'({n_m[j], {(F-1){1'b0}}}))) >>> F);
            assign n_qb[l][j] = NB'(n_q[l][j]) + QBIAS;

            always_comb begin
                if (r_m[j] == 2'd3) begin
                    n_quo = $signed(QW'(NB'(r_rq[l][j] >> SH) - QHALF));
                end else if (r_m[j] == 2'd2) begin
                    n_quo = r_q[l][j] >>> 1;
                end else begin
                    n_quo = r_q[l][j];
                end
                n_wnew = W'(QW'(r_wb[l][j-1]) + n_quo);
            end

            always_ff @(posedge i_clk) begin
                if (i_ld.s_a) begin
                    r_prod[l][j] <= PW'(DW'(i_w[l][j]) - DW'(i_w[l][j-1])) * PW'(w_t[j]);
                end
                if (i_ld.s_b) begin
                    r_q[l][j]  <= n_q[l][j];
                    r_rq[l][j] <= (2*NB)'(n_qb[l][j]) * (2*NB)'(RECIP);
                end
                if (i_ld.s_c) begin
                    r_wc[l][j] <= n_wnew;
                end
            end
        end
    end

    for (genvar j = 0; j < R; j++) begin : g_keep
        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (i_ld.s_c) begin
                    r_wc[l][j] <= r_wb[l][j];
                end
            end
        end
    end

    assign o_w = r_wc;

endmodule

/* rtl/cubic_bspline_curve_eval_unit.sv */
`timescale 1ns / 1ps
// Clamped uniform cubic B-spline evaluator, nine control points.
// i_req carries one curve parameter param_u (Q1.U_FRAC_BITS, values at or
// above 1.0 give the end point (1,0)). o_rsp returns one point per request:
// point_x (Q1.U_FRAC_BITS) and point_y (signed Q1.(Y_BITS-1), saturated).
// The seven interior control y values are written on the cfg port
// (index 0..6, higher indexes ignored) while no request is in flight.
// Throughput: one request per cycle unless o_rsp stalls, in the 12-stage pipeline: a front
// stage, three de Boor levels of three stages (one multiplier each for the
// blend and for the divide by three), and two output rounding stages.
// Every stage has its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up and i_req.ready stays high
// while any stage is empty, even when a result waits at o_rsp.
// When the receiver stalls, o_rsp holds its point and the pipeline fills
// up behind it without dropping or repeating anything.
// Reset clears all valid bits and the control y values to zero.
`include "cubic_bspline_curve_eval_unit_assert.svh"

module cubic_bspline_curve_eval_unit import cbs_pkg::*; #(
    parameter int U_FRAC_BITS = 16,
    parameter int Y_BITS      = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [Y_BITS-1:0]    i_cfg_wdata,
    cbs_req_if.sink              i_req,
    cbs_rsp_if.source            o_rsp
);

    localparam int F       = U_FRAC_BITS;
    localparam int UW      = F + 1;
    localparam int VW      = F + 3;
    localparam int W       = ((F + 4 > Y_BITS + 2) ? F + 4 : Y_BITS + 2) + 2;
    localparam int NUM_LVL = 3;
    localparam int LVL_STG = 3;
    localparam int ST_E1   = 1 + NUM_LVL * LVL_STG;
    localparam int ST_OUT  = ST_E1 + 1;
    localparam int NSTG    = ST_OUT + 1;
    localparam int XN      = W + 2;
    localparam int XSH     = XN + 1;
    localparam logic [XN-1:0] XREC  = XN'(((65'd1 << XSH) + 65'd2) / 65'd3);
    localparam logic [XN-1:0] XBIAS = XN'(3) << W;
    localparam logic [XN-1:0] XHALF = XN'(1) << W;
    localparam logic [UW-1:0] ONE_U = UW'(1) << F;
    localparam logic signed [W:0]   ONE_S  = (W+1)'(1) << F;
    localparam logic signed [W-1:0] YMAX_W = (W'(1) << (Y_BITS - 1)) - W'(1);
    localparam logic signed [W-1:0] YMIN_W = ~YMAX_W;

    logic signed [Y_BITS-1:0] r_ctrl_y [NUM_INNER];

    logic [NSTG-1:0]         r_vld;
    logic [NSTG-1:0]         w_ld;
    t_lvl_ld                 w_lvl_ld [NUM_LVL];

    logic [VW-1:0]           w_v;
    logic [SPAN_W-1:0]       w_k;
    logic signed [W-1:0]     n_s0_w [2][4];
    logic signed [W-1:0]     r_s0_w [2][4];
    logic [VW-1:0]           r_v_pipe [0:LVL_STG*(NUM_LVL-1)];
    logic [SPAN_W-1:0]       r_k_pipe [0:LVL_STG*(NUM_LVL-1)+1];
    logic                    r_end [0:ST_E1];
    logic signed [W-1:0]     w_lw [NUM_LVL+1][2][4];

    logic signed [W:0]       n_xh;
    logic [XN-1:0]           n_xb;
    logic signed [W-1:0]     n_yq;
    logic [2*XN-1:0]         r_xp;
    logic signed [W-1:0]     r_yq;
    logic signed [W:0]       n_xq;
    logic [UW-1:0]           n_px;
    logic signed [Y_BITS-1:0] n_py;
    logic [UW-1:0]           r_px;
    logic signed [Y_BITS-1:0] r_py;

    // Control y registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_INNER; i++) begin
                r_ctrl_y[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_INNER))) begin
            r_ctrl_y[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    // A stage loads when it or any stage after it is empty, or the output moves.
    for (genvar s = 0; s < NSTG; s++) begin : g_ld
        assign w_ld[s] = o_rsp.ready || !(&r_vld[NSTG-1:s]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_ld[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign i_req.ready = w_ld[0];

    // Front stage: v = 6u, segment, and the four active control points
    assign w_v = (VW'(i_req.param_u[F-1:0]) << 2) + (VW'(i_req.param_u[F-1:0]) << 1);
    assign w_k = w_v[VW-1:F];

    always_comb begin
        logic [3:0] idx;
        for (int j = 0; j < 4; j++) begin
            idx = 4'(w_k) + 4'(j);
            n_s0_w[0][j] = W'({X_SIXTHS[idx], {F{1'b0}}});
            // end control points are pinned at zero
            if ((idx == 4'd0) || (idx == 4'(NUM_CTRL - 1))) begin
                n_s0_w[1][j] = '0;
            end else begin
                n_s0_w[1][j] = W'(r_ctrl_y[3'(idx - 4'd1)]) <<< GUARD_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s0_w      <= n_s0_w;
            r_v_pipe[0] <= w_v;
            r_k_pipe[0] <= w_k;
            r_end[0]    <= i_req.param_u[F];
        end
    end

    for (genvar s = 1; s <= LVL_STG*(NUM_LVL-1); s++) begin : g_vpipe
        always_ff @(posedge i_clk) begin
            if (w_ld[s]) begin
                r_v_pipe[s] <= r_v_pipe[s-1];
            end
        end
    end

    for (genvar s = 1; s <= LVL_STG*(NUM_LVL-1)+1; s++) begin : g_kpipe
        always_ff @(posedge i_clk) begin
            if (w_ld[s]) begin
                r_k_pipe[s] <= r_k_pipe[s-1];
            end
        end
    end

    for (genvar s = 1; s <= ST_E1; s++) begin : g_epipe
        always_ff @(posedge i_clk) begin
            if (w_ld[s]) begin
                r_end[s] <= r_end[s-1];
            end
        end
    end

    assign w_lw[0] = r_s0_w;

    for (genvar L = 0; L < NUM_LVL; L++) begin : g_lvl
        assign w_lvl_ld[L] = '{s_a: w_ld[LVL_STG*L+1],
                               s_b: w_ld[LVL_STG*L+2],
                               s_c: w_ld[LVL_STG*L+3]};

        cbs_deboor_lvl #(
            .R (L + 1),
            .F (F),
            .W (W)
        ) u_lvl (
            .i_clk (i_clk),
            .i_ld  (w_lvl_ld[L]),
            .i_v   (r_v_pipe[LVL_STG*L]),
            .i_k_a (r_k_pipe[LVL_STG*L]),
            .i_k_b (r_k_pipe[LVL_STG*L+1]),
            .i_w   (w_lw[L]),
            .o_w   (w_lw[L+1])
        );
    end

    // Output rounding: x / 6 as a half-shift then reciprocal multiply, y / 4
    assign n_xh = ((W+1)'(w_lw[NUM_LVL][0][3]) + (W+1)'(3)) >>> 1;
    assign n_xb = XN'(n_xh) + XBIAS;
    assign n_yq = W'(((W+1)'(w_lw[NUM_LVL][1][3]) + (W+1)'(2)) >>> 2);

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_E1]) begin
            r_xp <= (2*XN)'(n_xb) * (2*XN)'(XREC);
            r_yq <= n_yq;
        end
    end

    assign n_xq = $signed((W+1)'(XN'(r_xp >> XSH) - XHALF));

    always_comb begin
        if (n_xq < 0) begin
            n_px = '0;
        end else if (n_xq > ONE_S) begin
            n_px = ONE_U;
        end else begin
            n_px = UW'(n_xq);
        end
        if (r_yq > YMAX_W) begin
            n_py = Y_BITS'(YMAX_W);
        end else if (r_yq < YMIN_W) begin
            n_py = Y_BITS'(YMIN_W);
        end else begin
            n_py = Y_BITS'(r_yq);
        end
        // u at or past 1.0 closes the last span on the end point
        if (r_end[ST_E1]) begin
            n_px = ONE_U;
            n_py = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_OUT]) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    assign o_rsp.valid   = r_vld[ST_OUT];
    assign o_rsp.point_x = r_px;
    assign o_rsp.point_y = r_py;

    `CBS_ASSERT(a_ready_when_out_empty, i_clk, i_rst_n, !r_vld[ST_OUT] |-> w_ld[0])
    `CBS_ASSERT(a_front_holds_on_stall, i_clk, i_rst_n, (r_vld[0] && !w_ld[0]) |=> (r_vld[0] && $stable(r_k_pipe[0])))
    `CBS_ASSERT(a_x_not_past_one, i_clk, i_rst_n, r_vld[ST_OUT] |-> (r_px <= ONE_U))
    `CBS_ASSERT_ALWAYS(a_reset_flushes, i_clk, !i_rst_n |=> (r_vld == '0))

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import cbs_pkg::CFG_IDX_W;

    localparam int U_FRAC      = 16;
    localparam int Y_W         = 16;
    localparam int ONE         = 1 << U_FRAC;
    localparam int Y_GUARD     = 4;
    localparam int INNER_PTS   = 7;
    localparam int PER_PHASE   = 240;
    localparam int WATCH_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CTRL_Y1, REG_CTRL_Y2, REG_CTRL_Y3, REG_CTRL_Y4,
        REG_CTRL_Y5, REG_CTRL_Y6, REG_CTRL_Y7, REG_SPARE
    } t_cfg_reg;

    typedef enum {PROF_TOP, PROF_BOTTOM, PROF_ZIGZAG, PROF_RANDOM, PROF_TINY} t_profile;

    typedef struct {
        logic [U_FRAC:0]       x;
        logic signed [Y_W-1:0] y;
    } t_curve_point;

    class t_spline_board;
        t_curve_point expected_points[$];
        longint       ctrl_y[INNER_PTS];
        int           errors;

        function new();
            foreach (ctrl_y[i]) ctrl_y[i] = 0;
            errors = 0;
        endfunction

        // knots and x control positions are both a clamped ramp in sixths
        function longint clamp_units(int n);
            if (n < 0) return 0;
            if (n > 6) return 6;
            return longint'(n);
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
            return q;
        endfunction

        function longint round_half_up(longint a, longint b);
            return floor_div(2 * a + b, 2 * b);
        endfunction

        function longint ctrl_point_y(int j);
            if (j == 0 || j == INNER_PTS + 1) return 0;
            return ctrl_y[j-1] * Y_GUARD;
        endfunction

        // triangular de Boor sweep over the four points of segment k
        function longint de_boor_sweep(longint w[4], longint v, int k);
            int     idx;
            longint num;
            longint den;
            for (int r = 1; r <= 3; r++) begin
                for (int i = k + 3; i >= k + r; i--) begin
                    idx  = i - k;
                    num  = (w[idx] - w[idx-1]) * (v - clamp_units(i - 3) * ONE);
                    den  = (clamp_units(i + 1 - r) - clamp_units(i - 3)) * ONE;
                    w[idx] = w[idx-1] + round_half_up(num, den);
                end
            end
            return w[3];
        endfunction

        function void set_ctrl(t_cfg_reg idx, logic [Y_W-1:0] val);
            if (idx != REG_SPARE) ctrl_y[idx] = longint'($signed(val));
        endfunction

        function void note_request(logic [U_FRAC:0] raw_u);
            longint       u;
            longint       v;
            longint       xw[4];
            longint       yw[4];
            longint       xr;
            longint       yr;
            int           k;
            t_curve_point p;
            u = longint'(raw_u);
            if (u >= ONE) begin
                xr = ONE;
                yr = 0;
            end else begin
                v = 6 * u;
                k = int'(v >>> U_FRAC);
                for (int j = 0; j < 4; j++) begin
                    xw[j] = clamp_units(k + j - 1) * ONE;
                    yw[j] = ctrl_point_y(k + j);
                end
                xr = round_half_up(de_boor_sweep(xw, v, k), 6);
                yr = round_half_up(de_boor_sweep(yw, v, k), Y_GUARD);
                if (xr < 0) xr = 0;
                if (xr > ONE) xr = ONE;
                if (yr > 32767) yr = 32767;
                if (yr < -32768) yr = -32768;
            end
            p.x = (U_FRAC+1)'(xr);
            p.y = Y_W'(yr);
            expected_points.insert(expected_points.size(), p);
        endfunction

        function void check_point(logic [U_FRAC:0] x, logic signed [Y_W-1:0] y);
            t_curve_point p;
            if (expected_points.size() == 0) begin
                $error("unexpected point x=%0d y=%0d", x, y);
                errors++;
                return;
            end
            p = expected_points.pop_front();
            if (x !== p.x) begin
                $error("point_x expected %0d got %0d", p.x, x);
                errors++;
            end
            if (y !== p.y) begin
                $error("point_y expected %0d got %0d", p.y, y);
                errors++;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [Y_W-1:0]       cfg_wdata;

    int            idle_pct;
    int            stall_pct;
    int            quiet_cycles;
    t_spline_board board;

    cbs_req_if #(.U_FRAC_BITS(U_FRAC)) req_ch ();
    cbs_rsp_if #(.U_FRAC_BITS(U_FRAC), .Y_BITS(Y_W)) rsp_ch ();

    cubic_bspline_curve_eval_unit #(
        .U_FRAC_BITS(U_FRAC),
        .Y_BITS     (Y_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) board.note_request(req_ch.param_u);
            if (rsp_ch.valid && rsp_ch.ready) board.check_point(rsp_ch.point_x, rsp_ch.point_y);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCH_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    task automatic write_reg(t_cfg_reg idx, logic [Y_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        board.set_ctrl(idx, val);
        @(negedge i_clk);
    endtask

    task automatic load_profile(t_profile prof);
        logic [Y_W-1:0] val;
        for (int i = 0; i < INNER_PTS; i++) begin
            case (prof)
                PROF_TOP:    val = 16'h7fff;
                PROF_BOTTOM: val = 16'h8000;
                PROF_ZIGZAG: val = (i % 2 == 0) ? 16'h7fff : 16'h8000;
                PROF_TINY:   val = Y_W'($urandom_range(15)) - 16'd8;
                default:     val = Y_W'($urandom);
            endcase
            write_reg(t_cfg_reg'(i), val);
        end
        // spare index must be ignored
        write_reg(REG_SPARE, Y_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_request(logic [U_FRAC:0] u);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.param_u <= u;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [U_FRAC:0] pick_u();
        int unsigned sel;
        int          b;
        sel = $urandom_range(99);
        if (sel < 70) return (U_FRAC+1)'($urandom_range(ONE - 1));
        if (sel < 85) begin
            // near a segment boundary
            b = (ONE * $urandom_range(1, 5) + 5) / 6 + $urandom_range(4) - 2;
            return (U_FRAC+1)'(b);
        end
        if (sel < 92) return (sel % 2 == 0) ? (U_FRAC+1)'(ONE) : (U_FRAC+1)'(ONE - 1);
        // above one: top bit set, low bits random
        return {1'b1, U_FRAC'($urandom)};
    endfunction

    initial begin
        logic [U_FRAC:0] corner_u[$];
        t_profile        plan[$];
        corner_u = '{17'd0, 17'd1, 17'd2, 17'd10922, 17'd10923, 17'd21845, 17'd21846,
                     17'd32767, 17'd32768, 17'd43690, 17'd43691, 17'd54613, 17'd54614,
                     17'd65534, 17'd65535, 17'd65536, 17'd65537, 17'h1ffff};
        plan = '{PROF_TOP, PROF_BOTTOM, PROF_RANDOM, PROF_TINY, PROF_RANDOM,
                 PROF_ZIGZAG, PROF_RANDOM};
        board          = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = REG_CTRL_Y1;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.param_u = '0;
        rsp_ch.ready   = 1'b0;
        idle_pct       = 16;
        stall_pct      = 16;
        quiet_cycles   = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_profile(PROF_ZIGZAG);
        foreach (corner_u[i]) send_request(corner_u[i]);
        wait_drained();

        foreach (plan[p]) begin
            load_profile(plan[p]);
            // one phase runs with neither side idling
            idle_pct  = (p == 2) ? 0 : 16;
            stall_pct = (p == 2) ? 0 : 16;
            for (int n = 0; n < PER_PHASE; n++) begin
                if (p == 4 && n == PER_PHASE / 2) wait_drained();
                send_request(pick_u());
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
